/* rtl/timestamp_to_calendar_date_macros.svh */
// assertion macros shared by the timestamp_to_calendar_date rtl
`ifndef TIMESTAMP_TO_CALENDAR_DATE_MACROS_SVH
`define TIMESTAMP_TO_CALENDAR_DATE_MACROS_SVH

// property that must hold at every edge outside reset
`define TTCD_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ttcd: invariant violated");

// property that must hold in the same cycle whenever cond is true
`define TTCD_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ttcd: implication violated");

`endif

/* rtl/ttcd_pkg.sv */
package ttcd_pkg;

   localparam int EPOCH_W = 31;
   localparam int TIME_W  = 32;
   localparam int DAYS_W  = 16;
   localparam int TOD_W   = 17;
   localparam int SOH_W   = 12;
   localparam int ZONE_W  = 5;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
   localparam logic [10:0] BASE_YEAR     = 11'd1970;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

   // reciprocal multipliers for the constant divisions
   // (t >> 7) / 675, underestimate by at most one, fixed up afterwards
   localparam logic [25:0] RECIP_DAY   = 26'd50903316;
   localparam int          RECIP_DAY_SH = 35;
   // days / 1461, exact for 16-bit days
   localparam logic [16:0] RECIP_CYCLE = 17'd91868;
   localparam int          RECIP_CYCLE_SH = 27;
   // (tod >> 4) / 225, exact for 13-bit operand
   localparam logic [13:0] RECIP_HOUR  = 14'd9321;
   localparam int          RECIP_HOUR_SH = 21;
   // (soh >> 2) / 15, exact for 10-bit operand
   localparam logic [10:0] RECIP_MIN   = 11'd1093;
   localparam int          RECIP_MIN_SH = 14;

   // day of year at which each month ends, common year
   localparam logic [8:0] MONTH_END [12] = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   typedef struct packed {
      logic                valid;
      logic [DAYS_W-1:0]   days;
      logic [TOD_W-1:0]    tod;
   } ttcd_split_type;

   typedef struct packed {
      logic        valid;
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } ttcd_date_type;

   typedef struct packed {
      logic             valid;
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [SOH_W-1:0] soh;
      logic [SOH_W-1:0] min_secs;
   } ttcd_tod_type;

   function automatic logic [8:0] month_end(input logic [3:0] idx, input logic leap);
      logic [8:0] e;
      e = MONTH_END[idx];
      if (leap && idx != 4'd0) begin
         e = e + 9'd1;
      end
      return e;
   endfunction

endpackage

/* rtl/ttcd_day_split.sv */
module ttcd_day_split import ttcd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [EPOCH_W-1:0]         epoch,
   input  logic signed [ZONE_W-1:0]   zone,
   output ttcd_split_type             split
);

   // stage 1: zone adjust and clamp
   logic signed [17:0] off_secs;
   logic signed [32:0] adj;
   logic              v1_ff, v1_in;
   logic [TIME_W-1:0] t1_ff, t1_in;

   assign off_secs = 18'(zone) * $signed({6'd0, SECS_PER_HOUR});
   assign adj      = $signed({2'b00, epoch}) + 33'(off_secs);

   always_comb begin
      v1_in = in_valid;
      t1_in = adj[32] ? '0 : adj[TIME_W-1:0];
   end

   // stage 2: reciprocal product
   logic              v2_ff, v2_in;
   logic [TIME_W-1:0] t2_ff, t2_in;
   logic [50:0]       p2_ff, p2_in;

   always_comb begin
      v2_in = v1_ff;
      t2_in = t1_ff;
      p2_in = 51'(t1_ff[TIME_W-1:7]) * 51'(RECIP_DAY);
   end

   // stage 3: quotient estimate back to seconds
   logic              v3_ff, v3_in;
   logic [TIME_W-1:0] t3_ff, t3_in;
   logic [DAYS_W-1:0] q3_ff, q3_in;
   logic [TIME_W-1:0] qm3_ff, qm3_in;

   always_comb begin
      v3_in  = v2_ff;
      t3_in  = t2_ff;
      q3_in  = p2_ff[RECIP_DAY_SH +: DAYS_W];
      qm3_in = TIME_W'(33'(p2_ff[RECIP_DAY_SH +: DAYS_W]) * 33'(SECS_PER_DAY));
   end

   // stage 4: remainder and one-step correction
   logic [17:0]    r4;
   ttcd_split_type s4_ff, s4_in;

   always_comb begin
      r4       = 18'(t3_ff - qm3_ff);
      s4_in.valid = v3_ff;
      if (r4 >= 18'(SECS_PER_DAY)) begin
         s4_in.days = q3_ff + 1'b1;
         s4_in.tod  = TOD_W'(r4 - 18'(SECS_PER_DAY));
      end else begin
         s4_in.days = q3_ff;
         s4_in.tod  = TOD_W'(r4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else begin
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         v3_ff       <= v3_in;
         s4_ff.valid <= s4_in.valid;
      end
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      p2_ff      <= p2_in;
      t3_ff      <= t3_in;
      q3_ff      <= q3_in;
      qm3_ff     <= qm3_in;
      s4_ff.days <= s4_in.days;
      s4_ff.tod  <= s4_in.tod;
   end

   assign split = s4_ff;

endmodule

/* rtl/ttcd_date.sv */
module ttcd_date import ttcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ttcd_split_type split,
   output ttcd_date_type  date
);

   // stage 5: cycle reciprocal product
   logic              v5_ff, v5_in;
   logic [DAYS_W-1:0] d5_ff, d5_in;
   logic [32:0]       cp5_ff, cp5_in;

   always_comb begin
      v5_in  = split.valid;
      d5_in  = split.days;
      cp5_in = 33'(split.days) * 33'(RECIP_CYCLE);
   end

   // stage 6: four-year cycle count and its day count
   logic              v6_ff, v6_in;
   logic [DAYS_W-1:0] d6_ff, d6_in;
   logic [5:0]        c6_ff, c6_in;
   logic [DAYS_W-1:0] cm6_ff, cm6_in;

   always_comb begin
      v6_in  = v5_ff;
      d6_in  = d5_ff;
      c6_in  = cp5_ff[RECIP_CYCLE_SH +: 6];
      cm6_in = DAYS_W'(cp5_ff[RECIP_CYCLE_SH +: 6]) * DAYS_W'(DAYS_PER_CYCLE);
   end

   // stage 7: year inside the cycle, third year is leap
   logic [10:0] cr7;
   logic        v7_ff, v7_in;
   logic [10:0] y7_ff, y7_in;
   logic [8:0]  r7_ff, r7_in;
   logic        l7_ff, l7_in;

   always_comb begin
      cr7   = 11'(d6_ff - cm6_ff);
      v7_in = v6_ff;
      l7_in = 1'b0;
      y7_in = BASE_YEAR + {3'd0, c6_ff, 2'b00};
      if (cr7 < 11'(DAYS_PER_YEAR)) begin
         r7_in = 9'(cr7);
      end else if (cr7 < 11'd730) begin
         y7_in = y7_in + 11'd1;
         r7_in = 9'(cr7 - 11'd365);
      end else if (cr7 <= 11'd1095) begin
         y7_in = y7_in + 11'd2;
         r7_in = 9'(cr7 - 11'd730);
         l7_in = 1'b1;
      end else begin
         y7_in = y7_in + 11'd3;
         r7_in = 9'(cr7 - 11'd1096);
      end
   end

   // stage 8: twelve parallel month-end compares
   logic        v8_ff, v8_in;
   logic [10:0] y8_ff, y8_in;
   logic [8:0]  r8_ff, r8_in;
   logic        l8_ff, l8_in;
   logic [11:0] lt8_ff, lt8_in;

   always_comb begin
      v8_in = v7_ff;
      y8_in = y7_ff;
      r8_in = r7_ff;
      l8_in = l7_ff;
      for (int i = 0; i < 12; i++) begin
         lt8_in[i] = r7_ff < month_end(4'(i), l7_ff);
      end
   end

   // stage 9: pick first month that holds the day
   ttcd_date_type s9_ff, s9_in;
   logic          found9;

   always_comb begin
      s9_in.valid = v8_ff;
      s9_in.year  = y8_ff;
      s9_in.month = 4'd12;
      s9_in.day   = 5'd31;
      found9      = 1'b0;
      for (int i = 0; i < 12; i++) begin
         if (!found9 && lt8_ff[i]) begin
            found9      = 1'b1;
            s9_in.month = 4'(i + 1);
            if (i == 0) begin
               s9_in.day = 5'(r8_ff + 9'd1);
            end else begin
               s9_in.day = 5'(r8_ff - month_end(4'(i - 1), l8_ff) + 9'd1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff       <= 1'b0;
         v6_ff       <= 1'b0;
         v7_ff       <= 1'b0;
         v8_ff       <= 1'b0;
         s9_ff.valid <= 1'b0;
      end else begin
         v5_ff       <= v5_in;
         v6_ff       <= v6_in;
         v7_ff       <= v7_in;
         v8_ff       <= v8_in;
         s9_ff.valid <= s9_in.valid;
      end
      d5_ff       <= d5_in;
      cp5_ff      <= cp5_in;
      d6_ff       <= d6_in;
      c6_ff       <= c6_in;
      cm6_ff      <= cm6_in;
      y7_ff       <= y7_in;
      r7_ff       <= r7_in;
      l7_ff       <= l7_in;
      y8_ff       <= y8_in;
      r8_ff       <= r8_in;
      l8_ff       <= l8_in;
      lt8_ff      <= lt8_in;
      s9_ff.year  <= s9_in.year;
      s9_ff.month <= s9_in.month;
      s9_ff.day   <= s9_in.day;
   end

   assign date = s9_ff;

endmodule

/* rtl/ttcd_clock.sv */
module ttcd_clock import ttcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ttcd_split_type split,
   output ttcd_tod_type   tod
);

   // stage 5: hour reciprocal product
   logic             v5_ff, v5_in;
   logic [TOD_W-1:0] t5_ff, t5_in;
   logic [25:0]      hp5_ff, hp5_in;

   always_comb begin
      v5_in  = split.valid;
      t5_in  = split.tod;
      hp5_in = 26'(split.tod[TOD_W-1:4]) * 26'(RECIP_HOUR);
   end

   // stage 6: hour and its seconds
   logic             v6_ff, v6_in;
   logic [TOD_W-1:0] t6_ff, t6_in;
   logic [4:0]       h6_ff, h6_in;
   logic [TOD_W-1:0] hm6_ff, hm6_in;

   always_comb begin
      v6_in  = v5_ff;
      t6_in  = t5_ff;
      h6_in  = hp5_ff[RECIP_HOUR_SH +: 5];
      hm6_in = TOD_W'(hp5_ff[RECIP_HOUR_SH +: 5]) * TOD_W'(SECS_PER_HOUR);
   end

   // stage 7: seconds within the hour
   logic             v7_ff, v7_in;
   logic [4:0]       h7_ff, h7_in;
   logic [SOH_W-1:0] s7_ff, s7_in;

   always_comb begin
      v7_in = v6_ff;
      h7_in = h6_ff;
      s7_in = SOH_W'(t6_ff - hm6_ff);
   end

   // stage 8: minute reciprocal product
   logic             v8_ff, v8_in;
   logic [4:0]       h8_ff, h8_in;
   logic [SOH_W-1:0] s8_ff, s8_in;
   logic [20:0]      mp8_ff, mp8_in;

   always_comb begin
      v8_in  = v7_ff;
      h8_in  = h7_ff;
      s8_in  = s7_ff;
      mp8_in = 21'(s7_ff[SOH_W-1:2]) * 21'(RECIP_MIN);
   end

   // stage 9: minute and its seconds
   ttcd_tod_type s9_ff, s9_in;

   always_comb begin
      s9_in.valid    = v8_ff;
      s9_in.hour     = h8_ff;
      s9_in.soh      = s8_ff;
      s9_in.minute   = mp8_ff[RECIP_MIN_SH +: 6];
      s9_in.min_secs = SOH_W'(mp8_ff[RECIP_MIN_SH +: 6]) * SOH_W'(SECS_PER_MIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff       <= 1'b0;
         v6_ff       <= 1'b0;
         v7_ff       <= 1'b0;
         v8_ff       <= 1'b0;
         s9_ff.valid <= 1'b0;
      end else begin
         v5_ff       <= v5_in;
         v6_ff       <= v6_in;
         v7_ff       <= v7_in;
         v8_ff       <= v8_in;
         s9_ff.valid <= s9_in.valid;
      end
      t5_ff          <= t5_in;
      hp5_ff         <= hp5_in;
      t6_ff          <= t6_in;
      h6_ff          <= h6_in;
      hm6_ff         <= hm6_in;
      h7_ff          <= h7_in;
      s7_ff          <= s7_in;
      h8_ff          <= h8_in;
      s8_ff          <= s8_in;
      mp8_ff         <= mp8_in;
      s9_ff.hour     <= s9_in.hour;
      s9_ff.minute   <= s9_in.minute;
      s9_ff.soh      <= s9_in.soh;
      s9_ff.min_secs <= s9_in.min_secs;
   end

   assign tod = s9_ff;

endmodule

/* rtl/timestamp_to_calendar_date.sv */
// a transaction taken by start passes stages 1..10 in turn and shows on the rsp_ ports from the stage 10 register
// throughput: one transaction per cycle while busy is low, set by the ten-stage pipeline
// busy is high only while reset is asserted; the pipeline never stalls
// reset (synchronous, active high) clears the valid bits and sets the zone offset to 0
// transactions in flight at reset are dropped
`include "timestamp_to_calendar_date_macros.svh"

module timestamp_to_calendar_date import ttcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [EPOCH_W-1:0]  req_epoch_seconds,
   // zone offset register
   input  logic                csr_write_enable,
   input  logic [ZONE_W-1:0]   csr_write_data,
   // response channel
   output logic                rsp_strobe,
   output logic [10:0]         rsp_year,
   output logic [3:0]          rsp_month,
   output logic [4:0]          rsp_day_of_month,
   output logic [4:0]          rsp_hour,
   output logic [5:0]          rsp_minute,
   output logic [5:0]          rsp_second
);

   // zone offset in whole hours, two's complement, applied as written
   logic [ZONE_W-1:0] zone_ff, zone_in;

   always_comb begin
      zone_in = csr_write_enable ? csr_write_data : zone_ff;
   end

   // nothing is taken while reset holds the pipeline clear
   assign busy = reset;

   // stages 1..4: zone adjust, clamp at zero, split into days and time of day
   ttcd_split_type split;

   ttcd_day_split u_day_split (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .epoch    (req_epoch_seconds),
      .zone     ($signed(zone_ff)),
      .split    (split)
   );

   // stages 5..9: days into year, month and day on the plain four-year cycle
   ttcd_date_type date_out;

   ttcd_date u_date (
      .clock (clock),
      .reset (reset),
      .split (split),
      .date  (date_out)
   );

   // stages 5..9: time of day into hour, minute and leftover seconds
   ttcd_tod_type tod_out;

   ttcd_clock u_clock (
      .clock (clock),
      .reset (reset),
      .split (split),
      .tod   (tod_out)
   );

   // stage 10: output register, seconds of the minute finished here
   logic        strobe_ff, strobe_in;
   logic [10:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff, second_in;

   always_comb begin
      strobe_in = date_out.valid;
      second_in = 6'(tod_out.soh - tod_out.min_secs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         zone_ff   <= zone_in;
         strobe_ff <= strobe_in;
      end
      year_ff   <= date_out.year;
      month_ff  <= date_out.month;
      day_ff    <= date_out.day;
      hour_ff   <= tod_out.hour;
      minute_ff <= tod_out.minute;
      second_ff <= second_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_year         = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day_of_month = day_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;

   // the date and time-of-day pipelines must stay in lock step
   `TTCD_ASSERT_ALWAYS(a_chains_aligned, clock, reset, date_out.valid == tod_out.valid)
   // month search always lands on a real month and day
   `TTCD_ASSERT_IMPLY(a_date_range, clock, reset, rsp_strobe, rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month >= 5'd1)
   // reciprocal divides must never overshoot the time of day fields
   `TTCD_ASSERT_IMPLY(a_time_range, clock, reset, rsp_strobe, rsp_hour < 5'd24 && rsp_minute < 6'd60 && rsp_second < 6'd60)

endmodule
